// ----- rtl/mpbq_pkg.sv -----
package mpbq_pkg;

  // default depth of each of the three byte queues
  localparam int unsigned QueueDepthDefault = 32;

  // first realtime status byte; all bytes from here up are realtime
  localparam logic [7:0] RealtimeFirst = 8'hF8;

  // operation codes carried by an input transaction
  typedef enum logic [1:0] {
    OP_SEND     = 2'd0,
    OP_TX_READY = 2'd1,
    OP_RECEIVE  = 2'd2,
    OP_DRAIN    = 2'd3
  } op_e;

  // controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_LOAD = 3'b100
  } ctrl_state_e;

  // input transaction payload
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] byte_in;
  } in_item_t;

  // output transaction payload
  typedef struct packed {
    logic        accepted;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_request;
    logic        realtime_valid;
    logic [7:0]  realtime_byte;
    logic        parser_valid;
    logic [7:0]  parser_byte;
    logic [31:0] normal_drops;
    logic [31:0] realtime_drops;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
    logic load;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

// ----- rtl/mpbq_ring.sv -----
module mpbq_ring #(
  parameter int unsigned Depth = mpbq_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] wdata_i,
  input  logic       pop_i,
  output logic [7:0] rdata_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FillW = $clog2(Depth + 1);

  logic [7:0]       mem_q [Depth];
  logic [7:0]       rdata_q;
  logic [IdxW-1:0]  rd_q, rd_d;
  logic [IdxW-1:0]  wr_q, wr_d;
  logic [FillW-1:0] fill_q, fill_d;

  assign full_o  = (fill_q == FillW'(Depth));
  assign empty_o = (fill_q == '0);
  assign rdata_o = rdata_q;

  // pointer and fill update, indices wrap at the depth
  always_comb begin
    rd_d   = rd_q;
    wr_d   = wr_q;
    fill_d = fill_q;
    if (push_i) begin
      wr_d   = (wr_q == IdxW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      fill_d = fill_q + 1'b1;
    end else if (pop_i) begin
      rd_d   = (rd_q == IdxW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q   <= '0;
      wr_q   <= '0;
      fill_q <= '0;
    end else begin
      rd_q   <= rd_d;
      wr_q   <= wr_d;
      fill_q <= fill_d;
    end
  end

  // byte storage, registered read
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
    if (pop_i) begin
      rdata_q <= mem_q[rd_q];
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(Depth))
    else $error("queue fill beyond depth");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");
`endif

endmodule

// ----- rtl/mpbq_datapath.sv -----
module mpbq_datapath #(
  parameter int unsigned QueueDepth = mpbq_pkg::QueueDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mpbq_pkg::in_item_t    in_data_i,
  input  mpbq_pkg::ctrl_cmd_t   cmd_i,
  output mpbq_pkg::dp_status_t  status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output mpbq_pkg::out_item_t   out_data_o
);

  logic [1:0]  op_q;
  logic [7:0]  byte_q;
  logic        is_rt;
  logic        is_send, is_txrdy, is_recv, is_drain;

  logic        pri_push, pri_pop, pri_full, pri_empty;
  logic        norm_push, norm_pop, norm_full, norm_empty;
  logic        rx_push, rx_pop, rx_full, rx_empty;
  logic [7:0]  pri_rdata, norm_rdata, rx_rdata;

  logic        accepted_q, tx_valid_q, tx_from_pri_q, rt_valid_q, p_valid_q;
  logic        request_q, request_d;
  logic [31:0] norm_drops_q, norm_drops_d;
  logic [31:0] rt_drops_q, rt_drops_d;
  logic        out_valid_q, out_valid_d;
  mpbq_pkg::out_item_t out_q;
  mpbq_pkg::out_item_t out_d;

  // latch the transaction on capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= in_data_i.operation;
      byte_q <= in_data_i.byte_in;
    end
  end

  // operation decode
  always_comb begin
    is_send  = 1'b0;
    is_txrdy = 1'b0;
    is_recv  = 1'b0;
    is_drain = 1'b0;
    case (mpbq_pkg::op_e'(op_q))
      mpbq_pkg::OP_SEND:     is_send  = 1'b1;
      mpbq_pkg::OP_TX_READY: is_txrdy = 1'b1;
      mpbq_pkg::OP_RECEIVE:  is_recv  = 1'b1;
      mpbq_pkg::OP_DRAIN:    is_drain = 1'b1;
      default:               is_drain = 1'b0;
    endcase
  end

  assign is_rt = (byte_q >= mpbq_pkg::RealtimeFirst);

  // queue strobes, priority queue served first
  assign pri_push  = cmd_i.execute && is_send && is_rt && !pri_full;
  assign norm_push = cmd_i.execute && is_send && !is_rt && !norm_full;
  assign pri_pop   = cmd_i.execute && is_txrdy && !pri_empty;
  assign norm_pop  = cmd_i.execute && is_txrdy && pri_empty && !norm_empty;
  assign rx_push   = cmd_i.execute && is_recv && !is_rt && !rx_full;
  assign rx_pop    = cmd_i.execute && is_drain && !rx_empty;

  mpbq_ring #(.Depth(QueueDepth)) u_pri_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pri_push),
    .wdata_i (byte_q),
    .pop_i   (pri_pop),
    .rdata_o (pri_rdata),
    .full_o  (pri_full),
    .empty_o (pri_empty)
  );

  mpbq_ring #(.Depth(QueueDepth)) u_norm_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (norm_push),
    .wdata_i (byte_q),
    .pop_i   (norm_pop),
    .rdata_o (norm_rdata),
    .full_o  (norm_full),
    .empty_o (norm_empty)
  );

  mpbq_ring #(.Depth(QueueDepth)) u_rx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rx_push),
    .wdata_i (byte_q),
    .pop_i   (rx_pop),
    .rdata_o (rx_rdata),
    .full_o  (rx_full),
    .empty_o (rx_empty)
  );

  // per-transaction result flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      accepted_q    <= pri_push || norm_push || rx_push || (is_recv && is_rt);
      tx_valid_q    <= pri_pop || norm_pop;
      tx_from_pri_q <= pri_pop;
      rt_valid_q    <= is_recv && is_rt;
      p_valid_q     <= rx_pop;
    end
  end

  // request flag and drop counters
  always_comb begin
    request_d    = request_q;
    norm_drops_d = norm_drops_q;
    rt_drops_d   = rt_drops_q;
    if (cmd_i.execute) begin
      if (pri_push || norm_push) begin
        request_d = 1'b1;
      end
      if (is_txrdy && pri_empty && norm_empty) begin
        request_d = 1'b0;
      end
      if (is_send && is_rt && pri_full) begin
        rt_drops_d = rt_drops_q + 32'd1;
      end
      if (is_send && !is_rt && norm_full) begin
        norm_drops_d = norm_drops_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      request_q    <= 1'b0;
      norm_drops_q <= '0;
      rt_drops_q   <= '0;
    end else begin
      request_q    <= request_d;
      norm_drops_q <= norm_drops_d;
      rt_drops_q   <= rt_drops_d;
    end
  end

  // result assembly
  always_comb begin
    out_d                = '0;
    out_d.accepted       = accepted_q;
    out_d.tx_valid       = tx_valid_q;
    out_d.tx_byte        = tx_valid_q ? (tx_from_pri_q ? pri_rdata : norm_rdata) : 8'd0;
    out_d.tx_request     = request_q;
    out_d.realtime_valid = rt_valid_q;
    out_d.realtime_byte  = rt_valid_q ? byte_q : 8'd0;
    out_d.parser_valid   = p_valid_q;
    out_d.parser_byte    = p_valid_q ? rx_rdata : 8'd0;
    out_d.normal_drops   = norm_drops_q;
    out_d.realtime_drops = rt_drops_q;
  end

  // output register, holds while stalled
  assign out_valid_d = cmd_i.load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q <= out_d;
    end
  end

  assign status_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

// ----- rtl/mpbq_ctrl.sv -----
module mpbq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mpbq_pkg::dp_status_t status_i,
  output mpbq_pkg::ctrl_cmd_t  cmd_o
);

  mpbq_pkg::ctrl_state_e state_q, state_d;
  logic                  accept;

  assign in_stall_o = (state_q != mpbq_pkg::ST_IDLE);
  assign accept     = in_valid_i && (state_q == mpbq_pkg::ST_IDLE);

  // sequence: capture, execute, load result
  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    cmd_o.load    = 1'b0;
    case (state_q)
      mpbq_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          state_d       = mpbq_pkg::ST_EXEC;
        end
      end
      mpbq_pkg::ST_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = mpbq_pkg::ST_LOAD;
      end
      mpbq_pkg::ST_LOAD: begin
        if (!status_i.out_busy) begin
          cmd_o.load = 1'b1;
          state_d    = mpbq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mpbq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpbq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == mpbq_pkg::ST_EXEC))
    else $error("accepted transaction not executed");
  a_exec_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mpbq_pkg::ST_EXEC) |=> (state_q == mpbq_pkg::ST_LOAD))
    else $error("execute not followed by load");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == mpbq_pkg::ST_IDLE))
    else $error("load did not return to idle");
`endif

endmodule

// ----- rtl/midi_priority_byte_queue.sv -----
// MIDI byte router with a priority send queue, a normal send queue and a
// receive queue.
// Input channel (in_valid_i / in_stall_o / in_data_i): one transaction is
// one operation: queue a byte to send, transmitter ready, byte received,
// or drain the receive queue.
// Output channel (out_valid_o / out_stall_i / out_data_o): exactly one
// result transaction per input transaction, in order.
// Each transaction runs capture, queue update with registered queue read
// and result load in the controller sequence, and no new input is taken
// before that load; the load waits while the output register is held.
// A result waiting on a stalled receiver does not block the next accept;
// the following result is held back until the output register is free.
// Reset clears all queue pointers and fill counts, both 32-bit drop
// counters and the transmit-request flag; queue storage is not cleared.
// Realtime status bytes (0xF8 and up) take the priority queue on send and
// are forwarded at once on receive.
module midi_priority_byte_queue #(
  parameter int unsigned QueueDepth = mpbq_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mpbq_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mpbq_pkg::out_item_t out_data_o
);

  mpbq_pkg::ctrl_cmd_t  cmd;
  mpbq_pkg::dp_status_t status;

  mpbq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mpbq_datapath #(.QueueDepth(QueueDepth)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- sim/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = mpbq_pkg::QueueDepthDefault;
  localparam int unsigned NumRows = 25;
  localparam int unsigned RandomItems = 360;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned SettleCycles = 20;

  // which of the three byte rings an access goes to
  typedef enum int {
    RING_NORMAL,
    RING_PRIORITY,
    RING_RECEIVE
  } ring_e;

  // traffic flavor of one random burst
  typedef enum int {
    BURST_MIXED,
    BURST_SEND_NORMAL,
    BURST_SEND_REALTIME,
    BURST_TX,
    BURST_RECEIVE,
    BURST_DRAIN
  } burst_e;

  typedef struct {
    mpbq_pkg::op_e       op;
    logic [7:0]          data;
    bit                  typed;
    mpbq_pkg::out_item_t want;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  mpbq_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  mpbq_pkg::out_item_t out_data_o;

  // router state as the block should hold it
  logic [7:0]  ring_cells [3][Depth];
  int unsigned ring_head [3] = '{0, 0, 0};
  int unsigned ring_count [3] = '{0, 0, 0};
  logic [31:0] normal_drop_count = '0;
  logic [31:0] realtime_drop_count = '0;
  logic        send_request = 1'b0;

  mpbq_pkg::out_item_t due_reports [$];
  stim_row_t           directed_rows [NumRows];
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned steady_gaps = 0;

  midi_priority_byte_queue dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ring buffer helpers
  function automatic bit ring_push(ring_e r, logic [7:0] b);
    if (ring_count[r] >= Depth) return 1'b0;
    ring_cells[r][(ring_head[r] + ring_count[r]) % Depth] = b;
    ring_count[r]++;
    return 1'b1;
  endfunction

  function automatic bit ring_pop(ring_e r, output logic [7:0] b);
    b = '0;
    if (ring_count[r] == 0) return 1'b0;
    b = ring_cells[r][ring_head[r]];
    ring_head[r] = (ring_head[r] + 1) % Depth;
    ring_count[r]--;
    return 1'b1;
  endfunction

  // one router operation: update the rings and counters, build the report
  function automatic mpbq_pkg::out_item_t route_op(mpbq_pkg::in_item_t item);
    mpbq_pkg::out_item_t res;
    logic [7:0]          got;
    bit                  is_realtime;
    res = '0;
    is_realtime = item.byte_in >= mpbq_pkg::RealtimeFirst;
    case (mpbq_pkg::op_e'(item.operation))
      mpbq_pkg::OP_SEND: begin
        if (ring_push(is_realtime ? RING_PRIORITY : RING_NORMAL, item.byte_in)) begin
          res.accepted = 1'b1;
          send_request = 1'b1;
        end else if (is_realtime) begin
          realtime_drop_count++;
        end else begin
          normal_drop_count++;
        end
      end
      mpbq_pkg::OP_TX_READY: begin
        if (ring_pop(RING_PRIORITY, got) || ring_pop(RING_NORMAL, got)) begin
          res.tx_valid = 1'b1;
          res.tx_byte = got;
        end else begin
          send_request = 1'b0;
        end
      end
      mpbq_pkg::OP_RECEIVE: begin
        if (is_realtime) begin
          res.accepted = 1'b1;
          res.realtime_valid = 1'b1;
          res.realtime_byte = item.byte_in;
        end else begin
          res.accepted = ring_push(RING_RECEIVE, item.byte_in);
        end
      end
      default: begin
        if (ring_pop(RING_RECEIVE, got)) begin
          res.parser_valid = 1'b1;
          res.parser_byte = got;
        end
      end
    endcase
    res.tx_request = send_request;
    res.normal_drops = normal_drop_count;
    res.realtime_drops = realtime_drop_count;
    return res;
  endfunction

  // report with both drop counters still at zero
  function automatic mpbq_pkg::out_item_t make_result(logic acc, logic txv, logic [7:0] txb,
                                                      logic req, logic rtv, logic [7:0] rtb,
                                                      logic pv, logic [7:0] pb);
    mpbq_pkg::out_item_t res;
    res = '0;
    res.accepted = acc;
    res.tx_valid = txv;
    res.tx_byte = txb;
    res.tx_request = req;
    res.realtime_valid = rtv;
    res.realtime_byte = rtb;
    res.parser_valid = pv;
    res.parser_byte = pb;
    return res;
  endfunction

  // sender gap: mostly none, some short, a few long, with gap-free stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_gaps > 0) begin
      steady_gaps--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      steady_gaps = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic mpbq_pkg::in_item_t burst_item(burst_e mode);
    mpbq_pkg::in_item_t item;
    mpbq_pkg::op_e      main_op;
    bit                 is_realtime;
    is_realtime = $urandom_range(0, 3) == 0;
    case (mode)
      BURST_SEND_NORMAL: begin
        main_op = mpbq_pkg::OP_SEND;
        is_realtime = $urandom_range(0, 9) == 0;
      end
      BURST_SEND_REALTIME: begin
        main_op = mpbq_pkg::OP_SEND;
        is_realtime = $urandom_range(0, 9) != 0;
      end
      BURST_TX: main_op = mpbq_pkg::OP_TX_READY;
      BURST_RECEIVE: begin
        main_op = mpbq_pkg::OP_RECEIVE;
        is_realtime = $urandom_range(0, 5) == 0;
      end
      BURST_DRAIN: main_op = mpbq_pkg::OP_DRAIN;
      default: main_op = mpbq_pkg::op_e'($urandom_range(0, 3));
    endcase
    // a little noise inside the focused bursts
    if (mode != BURST_MIXED && $urandom_range(0, 7) == 0) begin
      main_op = mpbq_pkg::op_e'($urandom_range(0, 3));
    end
    item.operation = main_op;
    item.byte_in = is_realtime ? 8'($urandom_range(8'hF8, 8'hFF))
                               : 8'($urandom_range(0, 8'hF7));
    return item;
  endfunction

  // present one transaction, wait for its acceptance, queue what it should report
  task automatic send_item(mpbq_pkg::in_item_t item, bit typed, mpbq_pkg::out_item_t want);
    int unsigned         gap;
    mpbq_pkg::out_item_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    predicted = route_op(item);
    due_reports.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic check_result(mpbq_pkg::out_item_t got, mpbq_pkg::out_item_t want);
    if (got.accepted !== want.accepted) begin
      $error("accepted: expected %0h, got %0h", want.accepted, got.accepted);
      mismatches++;
    end
    if (got.tx_valid !== want.tx_valid) begin
      $error("tx_valid: expected %0h, got %0h", want.tx_valid, got.tx_valid);
      mismatches++;
    end
    if (got.tx_byte !== want.tx_byte) begin
      $error("tx_byte: expected %0h, got %0h", want.tx_byte, got.tx_byte);
      mismatches++;
    end
    if (got.tx_request !== want.tx_request) begin
      $error("tx_request: expected %0h, got %0h", want.tx_request, got.tx_request);
      mismatches++;
    end
    if (got.realtime_valid !== want.realtime_valid) begin
      $error("realtime_valid: expected %0h, got %0h", want.realtime_valid, got.realtime_valid);
      mismatches++;
    end
    if (got.realtime_byte !== want.realtime_byte) begin
      $error("realtime_byte: expected %0h, got %0h", want.realtime_byte, got.realtime_byte);
      mismatches++;
    end
    if (got.parser_valid !== want.parser_valid) begin
      $error("parser_valid: expected %0h, got %0h", want.parser_valid, got.parser_valid);
      mismatches++;
    end
    if (got.parser_byte !== want.parser_byte) begin
      $error("parser_byte: expected %0h, got %0h", want.parser_byte, got.parser_byte);
      mismatches++;
    end
    if (got.normal_drops !== want.normal_drops) begin
      $error("normal_drops: expected %0h, got %0h", want.normal_drops, got.normal_drops);
      mismatches++;
    end
    if (got.realtime_drops !== want.realtime_drops) begin
      $error("realtime_drops: expected %0h, got %0h", want.realtime_drops, got.realtime_drops);
      mismatches++;
    end
  endtask

  // result checking and the no-progress watchdog
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (due_reports.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatches++;
      end else begin
        check_result(out_data_o, due_reports.pop_front());
      end
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("timeout: no transaction for %0d cycles", IdleLimit);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stalls: mostly short, a few long, with long stall-free runs
  initial begin : out_stall_driver
    int unsigned run;
    int unsigned hold;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      run = ($urandom_range(0, 99) < 15) ? $urandom_range(30, 80) : $urandom_range(1, 6);
      out_stall_i <= 1'b0;
      repeat (run) @(posedge clk_i);
      hold = ($urandom_range(0, 99) < 10) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      out_stall_i <= 1'b1;
      repeat (hold) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    mpbq_pkg::in_item_t item;
    burst_e             mode;
    int                 len;

    // edges of the byte range, priority order, ignored bytes, empty queues
    directed_rows = '{
      '{mpbq_pkg::OP_TX_READY, 8'h00, 1'b1, make_result(0, 0, 8'h00, 0, 0, 8'h00, 0, 8'h00)},
      '{mpbq_pkg::OP_DRAIN,    8'h00, 1'b1, make_result(0, 0, 8'h00, 0, 0, 8'h00, 0, 8'h00)},
      '{mpbq_pkg::OP_SEND,     8'h00, 1'b1, make_result(1, 0, 8'h00, 1, 0, 8'h00, 0, 8'h00)},
      '{mpbq_pkg::OP_SEND,     8'hF7, 1'b1, make_result(1, 0, 8'h00, 1, 0, 8'h00, 0, 8'h00)},
      '{mpbq_pkg::OP_SEND,     8'hF8, 1'b1, make_result(1, 0, 8'h00, 1, 0, 8'h00, 0, 8'h00)},
      '{mpbq_pkg::OP_SEND,     8'hFF, 1'b1, make_result(1, 0, 8'h00, 1, 0, 8'h00, 0, 8'h00)},
      '{mpbq_pkg::OP_TX_READY, 8'h00, 1'b1, make_result(0, 1, 8'hF8, 1, 0, 8'h00, 0, 8'h00)},
      '{mpbq_pkg::OP_TX_READY, 8'h00, 1'b1, make_result(0, 1, 8'hFF, 1, 0, 8'h00, 0, 8'h00)},
      '{mpbq_pkg::OP_TX_READY, 8'h00, 1'b1, make_result(0, 1, 8'h00, 1, 0, 8'h00, 0, 8'h00)},
      '{mpbq_pkg::OP_TX_READY, 8'h00, 1'b1, make_result(0, 1, 8'hF7, 1, 0, 8'h00, 0, 8'h00)},
      '{mpbq_pkg::OP_TX_READY, 8'h00, 1'b1, make_result(0, 0, 8'h00, 0, 0, 8'h00, 0, 8'h00)},
      '{mpbq_pkg::OP_TX_READY, 8'hFF, 1'b1, make_result(0, 0, 8'h00, 0, 0, 8'h00, 0, 8'h00)},
      '{mpbq_pkg::OP_RECEIVE,  8'hF8, 1'b1, make_result(1, 0, 8'h00, 0, 1, 8'hF8, 0, 8'h00)},
      '{mpbq_pkg::OP_RECEIVE,  8'hFF, 1'b1, make_result(1, 0, 8'h00, 0, 1, 8'hFF, 0, 8'h00)},
      '{mpbq_pkg::OP_RECEIVE,  8'h00, 1'b1, make_result(1, 0, 8'h00, 0, 0, 8'h00, 0, 8'h00)},
      '{mpbq_pkg::OP_RECEIVE,  8'hF7, 1'b1, make_result(1, 0, 8'h00, 0, 0, 8'h00, 0, 8'h00)},
      '{mpbq_pkg::OP_DRAIN,    8'hAA, 1'b1, make_result(0, 0, 8'h00, 0, 0, 8'h00, 1, 8'h00)},
      '{mpbq_pkg::OP_DRAIN,    8'h00, 1'b1, make_result(0, 0, 8'h00, 0, 0, 8'h00, 1, 8'hF7)},
      '{mpbq_pkg::OP_DRAIN,    8'hFF, 1'b1, make_result(0, 0, 8'h00, 0, 0, 8'h00, 0, 8'h00)},
      '{mpbq_pkg::OP_SEND,     8'h55, 1'b0, '0},
      '{mpbq_pkg::OP_RECEIVE,  8'hAA, 1'b0, '0},
      '{mpbq_pkg::OP_SEND,     8'hF9, 1'b0, '0},
      '{mpbq_pkg::OP_TX_READY, 8'h5A, 1'b0, '0},
      '{mpbq_pkg::OP_DRAIN,    8'h00, 1'b0, '0},
      '{mpbq_pkg::OP_TX_READY, 8'h00, 1'b0, '0}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[i]) begin
      item.operation = directed_rows[i].op;
      item.byte_in = directed_rows[i].data;
      send_item(item, directed_rows[i].typed, directed_rows[i].want);
    end

    // random bursts that fill, overflow and empty the rings
    while (items_sent < NumRows + RandomItems) begin
      mode = burst_e'($urandom_range(0, 5));
      len = (mode == BURST_MIXED) ? $urandom_range(5, 20) : $urandom_range(10, 60);
      repeat (len) begin
        send_item(burst_item(mode), 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    // drain outstanding results, then let the pipeline settle
    while (due_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mpbq_pkg.sv
rtl/mpbq_ring.sv
rtl/mpbq_datapath.sv
rtl/mpbq_ctrl.sv
rtl/midi_priority_byte_queue.sv
sim/testbench.sv
